[sv/vrte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrte_pkg
// Shared types and constants of the VRAM rectangle transfer engine.
// ----------------------------------------------------------------------------
package vrte_pkg;

    localparam int X_BITS       = 10;
    localparam int Y_BITS       = 9;
    localparam int STORE_WIDTH  = 1 << X_BITS;
    localparam int STORE_HEIGHT = 1 << Y_BITS;
    localparam int ADDR_BITS    = X_BITS + Y_BITS;
    localparam int STORE_DEPTH  = 1 << ADDR_BITS;

    localparam logic [1:0] XFER_IDLE       = 2'd0;
    localparam logic [1:0] XFER_TO_STORE   = 2'd1;
    localparam logic [1:0] XFER_FROM_STORE = 2'd2;

    localparam logic [7:0] OP_COPY_FIRST = 8'h80;
    localparam logic [7:0] OP_COPY_LAST  = 8'h9F;
    localparam logic [7:0] OP_WRITE_LAST = 8'hBF;
    localparam logic [7:0] OP_READ_LAST  = 8'hDF;

    localparam logic CFG_CHECK_MASK = 1'b0;
    localparam logic CFG_FORCE_MASK = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        from_store;
    } out_item_t;

endpackage

[sv/vram_rectangle_transfer_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vram_rectangle_transfer_engine_core
// Command decoder, rectangle scanner and single-port pixel store.
// ----------------------------------------------------------------------------
// After reset the block clears its 1024 x 512 pixel store, one pixel per
// cycle, and accepts no item during that pass (configuration writes are
// taken). All timing is set by the single store port. A data word writes
// its pixels in turn, each read first and written only if its mask bit is
// clear when check_mask is on. A read strobe reads and captures each pixel
// returned, then loads the output register once it is free. The last word
// of a copy command reads, captures and writes each pixel copied, with the
// check_mask read before the write. A finished read result waits in the
// output register while the next item is accepted.
module vram_rectangle_transfer_engine_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  vrte_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output vrte_pkg::out_item_t  out_item,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic                 cfg_data
);
    import vrte_pkg::*;

    typedef enum logic [8:0]
    {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_PUT      = 9'b000000100,
        S_PUT_CHK  = 9'b000001000,
        S_GET      = 9'b000010000,
        S_GET_CAP  = 9'b000100000,
        S_OUT      = 9'b001000000,
        S_COPY_SRC = 9'b010000000,
        S_COPY_TGT = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                 check_mask_reg, check_mask_next;
    logic                 force_mask_reg, force_mask_next;
    logic [1:0]           mode_reg, mode_next;
    logic [7:0]           header_reg, header_next;
    logic [1:0]           wc_reg, wc_next;
    logic                 out_valid_reg, out_valid_next;

    logic [31:0]          source_reg, source_next;
    logic [31:0]          target_reg, target_next;
    logic [X_BITS-1:0]    base_x_reg, base_x_next;
    logic [Y_BITS-1:0]    base_y_reg, base_y_next;
    logic [X_BITS:0]      width_reg, width_next;
    logic [Y_BITS:0]      height_reg, height_next;
    logic [X_BITS-1:0]    col_reg, col_next;
    logic [Y_BITS-1:0]    row_reg, row_next;
    logic [X_BITS-1:0]    cp_sx_reg, cp_sx_next;
    logic [Y_BITS-1:0]    cp_sy_reg, cp_sy_next;
    logic [X_BITS-1:0]    cp_tx_reg, cp_tx_next;
    logic [Y_BITS-1:0]    cp_ty_reg, cp_ty_next;
    logic [X_BITS:0]      cp_w_reg, cp_w_next;
    logic [Y_BITS:0]      cp_h_reg, cp_h_next;
    logic [X_BITS-1:0]    cp_x_reg, cp_x_next;
    logic [Y_BITS-1:0]    cp_y_reg, cp_y_next;
    logic                 copy_reg, copy_next;
    logic                 half_reg, half_next;
    logic [31:0]          word_reg, word_next;
    logic [15:0]          pix_reg, pix_next;
    logic [31:0]          pack_reg, pack_next;
    logic                 from_reg, from_next;
    out_item_t            out_reg, out_next;

    logic [15:0]          mem [STORE_DEPTH];
    logic [15:0]          mem_rdata;
    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [15:0]          mem_wdata;

    logic                 accept;
    logic [7:0]           op_in;
    logic [X_BITS-1:0]    xfer_x, cp_src_x, cp_tgt_x;
    logic [Y_BITS-1:0]    xfer_y, cp_src_y, cp_tgt_y;
    logic [ADDR_BITS-1:0] xfer_addr, cp_src_addr, put_addr;
    logic [15:0]          put_val;
    logic [X_BITS:0]      col_inc, cp_x_inc;
    logic [Y_BITS:0]      row_inc, cp_y_inc;
    logic                 xfer_done, cp_done, put_last;
    logic                 adv_xfer, adv_copy, out_free;
    logic [X_BITS:0]      size_w;
    logic [Y_BITS:0]      size_h;
    logic [15:0]          size_xm1, size_ym1;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign op_in     = in_item.word[31:24];

    assign xfer_x      = base_x_reg + col_reg;
    assign xfer_y      = base_y_reg + row_reg;
    assign xfer_addr   = {xfer_y, xfer_x};
    assign cp_src_x    = cp_sx_reg + cp_x_reg;
    assign cp_src_y    = cp_sy_reg + cp_y_reg;
    assign cp_src_addr = {cp_src_y, cp_src_x};
    assign cp_tgt_x    = cp_tx_reg + cp_x_reg;
    assign cp_tgt_y    = cp_ty_reg + cp_y_reg;
    assign put_addr    = copy_reg ? {cp_tgt_y, cp_tgt_x} : xfer_addr;
    assign put_val     = copy_reg ? pix_reg : (half_reg ? word_reg[31:16] : word_reg[15:0]);

    assign col_inc   = {1'b0, col_reg} + (X_BITS+1)'(1);
    assign row_inc   = {1'b0, row_reg} + (Y_BITS+1)'(1);
    assign cp_x_inc  = {1'b0, cp_x_reg} + (X_BITS+1)'(1);
    assign cp_y_inc  = {1'b0, cp_y_reg} + (Y_BITS+1)'(1);
    assign xfer_done = (col_inc >= width_reg) && (row_inc >= height_reg);
    assign cp_done   = (cp_x_inc >= cp_w_reg) && (cp_y_inc >= cp_h_reg);
    assign put_last  = copy_reg ? cp_done : (xfer_done || half_reg);

    assign size_xm1 = in_item.word[15:0] - 16'd1;
    assign size_ym1 = in_item.word[31:16] - 16'd1;
    assign size_w   = {1'b0, size_xm1[X_BITS-1:0]} + (X_BITS+1)'(1);
    assign size_h   = {1'b0, size_ym1[Y_BITS-1:0]} + (Y_BITS+1)'(1);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        check_mask_next = check_mask_reg;
        force_mask_next = force_mask_reg;
        mode_next       = mode_reg;
        header_next     = header_reg;
        wc_next         = wc_reg;
        out_valid_next  = out_valid_reg && out_stall;
        source_next     = source_reg;
        target_next     = target_reg;
        base_x_next     = base_x_reg;
        base_y_next     = base_y_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cp_sx_next      = cp_sx_reg;
        cp_sy_next      = cp_sy_reg;
        cp_tx_next      = cp_tx_reg;
        cp_ty_next      = cp_ty_reg;
        cp_w_next       = cp_w_reg;
        cp_h_next       = cp_h_reg;
        cp_x_next       = cp_x_reg;
        cp_y_next       = cp_y_reg;
        copy_next       = copy_reg;
        half_next       = half_reg;
        word_next       = word_reg;
        pix_next        = pix_reg;
        pack_next       = pack_reg;
        from_next       = from_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = put_addr;
        mem_wdata       = {put_val[15] | force_mask_reg, put_val[14:0]};
        adv_xfer        = 1'b0;
        adv_copy        = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CHECK_MASK: check_mask_next = cfg_data;
                CFG_FORCE_MASK: force_mask_next = cfg_data;
                default:        check_mask_next = check_mask_reg;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = 16'h0000;
                clr_cnt_next = clr_cnt_reg + ADDR_BITS'(1);
                if (&clr_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.mode)
                    begin
                        pack_next = 32'h0;
                        half_next = 1'b0;
                        if (mode_reg == XFER_FROM_STORE)
                        begin
                            from_next  = 1'b1;
                            state_next = S_GET;
                        end
                        else
                        begin
                            from_next  = 1'b0;
                            state_next = S_OUT;
                        end
                    end
                    else if (mode_reg == XFER_TO_STORE)
                    begin
                        word_next  = in_item.word;
                        half_next  = 1'b0;
                        copy_next  = 1'b0;
                        state_next = S_PUT;
                    end
                    else
                    begin
                        priority if (wc_reg == 2'd0)
                        begin
                            if (op_in >= OP_COPY_FIRST && op_in <= OP_READ_LAST)
                            begin
                                header_next = op_in;
                                wc_next     = 2'd1;
                            end
                        end
                        else if (wc_reg == 2'd1)
                        begin
                            source_next = in_item.word;
                            wc_next     = 2'd2;
                        end
                        else if (header_reg <= OP_COPY_LAST && wc_reg == 2'd2)
                        begin
                            target_next = in_item.word;
                            wc_next     = 2'd3;
                        end
                        else if (header_reg <= OP_COPY_LAST)
                        begin
                            wc_next    = 2'd0;
                            cp_sx_next = source_reg[X_BITS-1:0];
                            cp_sy_next = source_reg[16 +: Y_BITS];
                            cp_tx_next = target_reg[X_BITS-1:0];
                            cp_ty_next = target_reg[16 +: Y_BITS];
                            cp_w_next  = size_w;
                            cp_h_next  = size_h;
                            cp_x_next  = '0;
                            cp_y_next  = '0;
                            copy_next  = 1'b1;
                            state_next = S_COPY_SRC;
                        end
                        else
                        begin
                            wc_next     = 2'd0;
                            base_x_next = source_reg[X_BITS-1:0];
                            base_y_next = source_reg[16 +: Y_BITS];
                            width_next  = size_w;
                            height_next = size_h;
                            col_next    = '0;
                            row_next    = '0;
                            mode_next   = (header_reg <= OP_WRITE_LAST) ?
                                          XFER_TO_STORE : XFER_FROM_STORE;
                        end
                    end
                end
            end
            S_PUT:
            begin
                if (check_mask_reg)
                begin
                    mem_re     = 1'b1;
                    state_next = S_PUT_CHK;
                end
                else
                begin
                    mem_we   = 1'b1;
                    adv_xfer = !copy_reg;
                    adv_copy = copy_reg;
                end
            end
            S_PUT_CHK:
            begin
                mem_we   = !mem_rdata[15];
                adv_xfer = !copy_reg;
                adv_copy = copy_reg;
            end
            S_GET:
            begin
                mem_re     = 1'b1;
                mem_addr   = xfer_addr;
                state_next = S_GET_CAP;
            end
            S_GET_CAP:
            begin
                adv_xfer = 1'b1;
                if (half_reg)
                begin
                    pack_next = {mem_rdata, pack_reg[15:0]};
                end
                else
                begin
                    pack_next = {16'h0000, mem_rdata};
                end
                if (xfer_done || half_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    half_next  = 1'b1;
                    state_next = S_GET;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.read_data  = pack_reg;
                    out_next.from_store = from_reg;
                    state_next          = S_IDLE;
                end
            end
            S_COPY_SRC:
            begin
                mem_re     = 1'b1;
                mem_addr   = cp_src_addr;
                state_next = S_COPY_TGT;
            end
            S_COPY_TGT:
            begin
                pix_next   = mem_rdata;
                state_next = S_PUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv_xfer)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                if (row_inc >= height_reg)
                begin
                    row_next  = '0;
                    mode_next = XFER_IDLE;
                end
                else
                begin
                    row_next = row_inc[Y_BITS-1:0];
                end
            end
            else
            begin
                col_next = col_inc[X_BITS-1:0];
            end
        end

        if (adv_copy)
        begin
            if (cp_x_inc >= cp_w_reg)
            begin
                cp_x_next = '0;
                cp_y_next = cp_y_inc[Y_BITS-1:0];
            end
            else
            begin
                cp_x_next = cp_x_inc[X_BITS-1:0];
            end
        end

        if ((state_reg == S_PUT && !check_mask_reg) || state_reg == S_PUT_CHK)
        begin
            if (put_last)
            begin
                state_next = S_IDLE;
            end
            else if (copy_reg)
            begin
                state_next = S_COPY_SRC;
            end
            else
            begin
                half_next  = 1'b1;
                state_next = S_PUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            check_mask_reg <= 1'b0;
            force_mask_reg <= 1'b0;
            mode_reg       <= XFER_IDLE;
            header_reg     <= 8'h00;
            wc_reg         <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            check_mask_reg <= check_mask_next;
            force_mask_reg <= force_mask_next;
            mode_reg       <= mode_next;
            header_reg     <= header_next;
            wc_reg         <= wc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        source_reg <= source_next;
        target_reg <= target_next;
        base_x_reg <= base_x_next;
        base_y_reg <= base_y_next;
        width_reg  <= width_next;
        height_reg <= height_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        cp_sx_reg  <= cp_sx_next;
        cp_sy_reg  <= cp_sy_next;
        cp_tx_reg  <= cp_tx_next;
        cp_ty_reg  <= cp_ty_next;
        cp_w_reg   <= cp_w_next;
        cp_h_reg   <= cp_h_next;
        cp_x_reg   <= cp_x_next;
        cp_y_reg   <= cp_y_next;
        copy_reg   <= copy_next;
        half_reg   <= half_next;
        word_reg   <= word_next;
        pix_reg    <= pix_next;
        pack_reg   <= pack_next;
        from_reg   <= from_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else if (mem_re)
        begin
            mem_rdata <= mem[mem_addr];
        end
    end

endmodule

[sim/vram_rectangle_transfer_engine_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vram_rectangle_transfer_engine_core_tb
// Self-checking bench for the VRAM rectangle transfer engine core.
// ----------------------------------------------------------------------------
// Streams command words, pixel words and read strobes into the core with
// random sender bursts and receiver stalls. A behavioral image of the pixel
// store and of the scan state predicts every read result, which is compared
// in order. Mask settings change between phases while the core is idle.
// ----------------------------------------------------------------------------
module vram_rectangle_transfer_engine_core_tb;
    import vrte_pkg::*;

    localparam logic [7:0] OP_WRITE_FIRST = OP_COPY_LAST + 8'd1;
    localparam logic [7:0] OP_READ_FIRST  = OP_WRITE_LAST + 8'd1;
    localparam int WATCHDOG_LIMIT = 1600000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int PHASE_ITEMS    = 140;
    localparam int HOLD_CYCLES    = 500;
    localparam int PHASES         = 5;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;
    logic      cfg_write = 1'b0;
    logic      cfg_index = 1'b0;
    logic      cfg_data  = 1'b0;

    vram_rectangle_transfer_engine_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bit   [15:0]       vram_image [STORE_DEPTH];
    logic              mask_check = 1'b0;
    logic              mask_force = 1'b0;
    logic [1:0]        xfer_state = XFER_IDLE;
    logic [7:0]        cmd_op     = '0;
    logic [1:0]        cmd_words  = '0;
    logic [31:0]       src_corner = '0;
    logic [31:0]       dst_corner = '0;
    logic [X_BITS-1:0] org_x      = '0;
    logic [X_BITS-1:0] col_pos    = '0;
    logic [Y_BITS-1:0] org_y      = '0;
    logic [Y_BITS-1:0] row_pos    = '0;
    logic [X_BITS:0]   span_w     = '0;
    logic [Y_BITS:0]   span_h     = '0;

    in_item_t  pending_items [$];
    out_item_t readback_due [$];

    bit in_took      = 1'b0;
    int idle_cycles  = 0;
    int mismatches   = 0;
    int items_sent   = 0;
    int items_queued = 0;
    int results_seen = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int hold_left    = 0;
    int hold_mark    = 40;
    int pattern_left = 0;
    int stall_pct    = 0;

    logic phase_check [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic phase_force [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [ADDR_BITS-1:0] pix_addr(logic [31:0] x, logic [31:0] y);
        return {y[Y_BITS-1:0], x[X_BITS-1:0]};
    endfunction

    function automatic logic [ADDR_BITS-1:0] scan_addr();
        return pix_addr(32'(org_x) + 32'(col_pos), 32'(org_y) + 32'(row_pos));
    endfunction

    function automatic logic [X_BITS:0] width_of(logic [31:0] size);
        logic [15:0] m;
        m = size[15:0] - 16'd1;
        return {1'b0, m[X_BITS-1:0]} + (X_BITS+1)'(1);
    endfunction

    function automatic logic [Y_BITS:0] height_of(logic [31:0] size);
        logic [15:0] m;
        m = size[31:16] - 16'd1;
        return {1'b0, m[Y_BITS-1:0]} + (Y_BITS+1)'(1);
    endfunction

    function automatic void put_pixel(logic [ADDR_BITS-1:0] a, logic [15:0] v);
        if (mask_check && vram_image[a][15])
            return;
        vram_image[a] = {v[15] | mask_force, v[14:0]};
    endfunction

    // advance the scan; returns 1 when the rectangle is done
    function automatic bit scan_step();
        if (int'(col_pos) + 1 < int'(span_w))
        begin
            col_pos = col_pos + X_BITS'(1);
            return 1'b0;
        end
        col_pos = '0;
        if (int'(row_pos) + 1 < int'(span_h))
        begin
            row_pos = row_pos + Y_BITS'(1);
            return 1'b0;
        end
        row_pos    = '0;
        xfer_state = XFER_IDLE;
        return 1'b1;
    endfunction

    function automatic void block_copy(logic [31:0] size);
        int xi;
        int yi;
        int w;
        int h;
        w = int'(width_of(size));
        h = int'(height_of(size));
        for (yi = 0; yi < h; yi++)
            for (xi = 0; xi < w; xi++)
                put_pixel(pix_addr(32'(dst_corner[15:0]) + xi, 32'(dst_corner[31:16]) + yi),
                          vram_image[pix_addr(32'(src_corner[15:0]) + xi,
                                              32'(src_corner[31:16]) + yi)]);
    endfunction

    function automatic void take_command(logic [31:0] w);
        if (cmd_words == 2'd0)
        begin
            if (w[31:24] < OP_COPY_FIRST || w[31:24] > OP_READ_LAST)
                return;
            cmd_op    = w[31:24];
            cmd_words = 2'd1;
            return;
        end
        if (cmd_words == 2'd1)
        begin
            src_corner = w;
            cmd_words  = 2'd2;
            return;
        end
        if (cmd_op <= OP_COPY_LAST)
        begin
            if (cmd_words == 2'd2)
            begin
                dst_corner = w;
                cmd_words  = 2'd3;
                return;
            end
            cmd_words = 2'd0;
            block_copy(w);
            return;
        end
        cmd_words  = 2'd0;
        org_x      = src_corner[X_BITS-1:0];
        org_y      = src_corner[16 +: Y_BITS];
        span_w     = width_of(w);
        span_h     = height_of(w);
        col_pos    = '0;
        row_pos    = '0;
        xfer_state = (cmd_op <= OP_WRITE_LAST) ? XFER_TO_STORE : XFER_FROM_STORE;
    endfunction

    function automatic void predict_readback(in_item_t it);
        out_item_t r;
        r = '0;
        if (!it.mode)
        begin
            if (xfer_state == XFER_TO_STORE)
            begin
                put_pixel(scan_addr(), it.word[15:0]);
                if (!scan_step())
                begin
                    put_pixel(scan_addr(), it.word[31:16]);
                    void'(scan_step());
                end
            end
            else
                take_command(it.word);
            return;
        end
        if (xfer_state == XFER_FROM_STORE)
        begin
            r.from_store      = 1'b1;
            r.read_data[15:0] = vram_image[scan_addr()];
            if (!scan_step())
            begin
                r.read_data[31:16] = vram_image[scan_addr()];
                void'(scan_step());
            end
        end
        readback_due.push_back(r);
    endfunction

    function automatic void push_word(logic [31:0] w);
        in_item_t it;
        it.mode = 1'b0;
        it.word = w;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    function automatic void push_read();
        in_item_t it;
        it.mode = 1'b1;
        it.word = $urandom;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    function automatic logic [31:0] pick_corner();
        logic [15:0] x;
        logic [15:0] y;
        int r;
        r = $urandom_range(0, 9);
        x = 16'($urandom);
        y = 16'($urandom);
        if (r < 7)
        begin
            x[X_BITS-1:0] = X_BITS'($urandom_range(0, 23));
            y[Y_BITS-1:0] = Y_BITS'($urandom_range(0, 11));
        end
        else if (r < 9)
        begin
            x[X_BITS-1:0] = X_BITS'($urandom_range(STORE_WIDTH - 8, STORE_WIDTH - 1));
            y[Y_BITS-1:0] = Y_BITS'($urandom_range(STORE_HEIGHT - 6, STORE_HEIGHT - 1));
        end
        return {y, x};
    endfunction

    function automatic logic [31:0] encode_size(int w, int h);
        logic [15:0] sw;
        logic [15:0] sh;
        sw = 16'(w + STORE_WIDTH * $urandom_range(0, 63));
        sh = 16'(h + STORE_HEIGHT * $urandom_range(0, 127));
        return {sh, sw};
    endfunction

    function automatic void queue_directed();
        push_read();
        push_word(32'h0000_0000);
        push_word(32'hFFFF_FFFF);
        push_word({OP_WRITE_FIRST, 24'h00_0000});
        push_word(32'hFFFF_FFFF);
        push_word(32'hFE01_FC03);
        push_word(32'h8001_7FFF);
        push_word(32'h1234_FFFF);
        push_word({OP_READ_LAST, 24'hFF_FFFF});
        push_word(32'hFFFF_FFFF);
        push_word(32'h0001_0003);
        push_read();
        push_read();
        push_word({OP_COPY_FIRST, 24'h5A_5A5A});
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0005);
        push_word(32'h0001_0000);
        push_word({OP_COPY_LAST, 24'hA5_A5A5});
        push_word(32'h0000_03FF);
        push_word(32'h01FF_0010);
        push_word(32'h0000_0001);
        push_word({OP_READ_FIRST, 24'h00_0000});
        push_word(32'h0000_0005);
        push_word(32'h0002_0004);
        push_read();
        push_word({OP_WRITE_LAST, 24'h00_0000});
        push_word(32'h0000_0000);
        push_word(32'h0001_0002);
        push_word(32'hFFFF_8000);
    endfunction

    function automatic void queue_random_phase(int goal);
        int r;
        int w;
        int h;
        int n;
        int k;
        logic [7:0] op;
        goal += items_queued;
        while (items_queued < goal)
        begin
            r = $urandom_range(0, 99);
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 4);
            n = (w * h + 1) / 2;
            if (r < 35)
            begin
                push_word({8'($urandom_range(OP_WRITE_FIRST, OP_WRITE_LAST)), 24'($urandom)});
                push_word(pick_corner());
                push_word(encode_size(w, h));
                repeat (n) push_word($urandom);
            end
            else if (r < 65)
            begin
                push_word({8'($urandom_range(OP_READ_FIRST, OP_READ_LAST)), 24'($urandom)});
                push_word(pick_corner());
                push_word(encode_size(w, h));
                k = $urandom_range(0, 7);
                if (k == 0)
                    n = n + 1;
                else if (k == 1 && n > 1)
                    n = $urandom_range(1, n - 1);
                repeat (n) push_read();
            end
            else if (r < 80)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    w = STORE_WIDTH;
                    h = 1;
                end
                push_word({8'($urandom_range(OP_COPY_FIRST, OP_COPY_LAST)), 24'($urandom)});
                push_word(pick_corner());
                push_word(pick_corner());
                push_word(encode_size(w, h));
            end
            else if (r < 88)
            begin
                if ($urandom_range(0, 1) == 0)
                    op = 8'($urandom_range(0, OP_COPY_FIRST - 1));
                else
                    op = 8'($urandom_range(OP_READ_LAST + 1, 255));
                push_word({op, 24'($urandom)});
            end
            else if (r < 94)
                push_read();
            else
            begin
                // abandon a read of arbitrary size
                push_word({8'($urandom_range(OP_READ_FIRST, OP_READ_LAST)), 24'($urandom)});
                push_word($urandom);
                push_word($urandom);
                repeat ($urandom_range(1, 3)) push_read();
            end
        end
    endfunction

    task automatic write_mask_regs(logic chk, logic frc);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_CHECK_MASK;
        cfg_data  <= chk;
        @(negedge clk);
        cfg_index <= CFG_FORCE_MASK;
        cfg_data  <= frc;
        @(negedge clk);
        cfg_write <= 1'b0;
        mask_check = chk;
        mask_force = frc;
    endtask

    // a final read proves the engine has finished every earlier item
    task automatic drain_phase();
        push_read();
        while (pending_items.size() > 0 || in_valid || readback_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at result %0d: got %h, expected %h",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    always @(negedge clk)
    begin
        logic     nxt_valid;
        in_item_t nxt_item;
        nxt_valid = in_valid;
        nxt_item  = in_item;
        if (in_valid && in_took)
            nxt_valid = 1'b0;
        if (!nxt_valid && rst_n)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_items.size() > 0)
            begin
                nxt_item  = pending_items.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        in_valid <= nxt_valid;
        in_item  <= nxt_item;
    end

    always @(negedge clk)
    begin
        int pick;
        if (results_seen >= hold_mark)
        begin
            hold_left = HOLD_CYCLES;
            hold_mark += 150;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pick         = $urandom_range(0, 3);
                stall_pct    = (pick == 0) ? 0 : (pick == 1) ? 25 : (pick == 2) ? 60 : 90;
                pattern_left = $urandom_range(4, 64);
            end
            pattern_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        bit        out_took;
        if (rst_n)
        begin
            in_took  = in_valid && !in_stall;
            out_took = out_valid && !out_stall;
            if (out_took)
            begin
                results_seen++;
                if (readback_due.size() == 0)
                    flag_mismatch("unexpected result", out_item.read_data, 32'd0);
                else
                begin
                    want = readback_due.pop_front();
                    if (out_item.read_data !== want.read_data)
                        flag_mismatch("read_data", out_item.read_data, want.read_data);
                    if (out_item.from_store !== want.from_store)
                        flag_mismatch("from_store", 32'(out_item.from_store),
                                      32'(want.from_store));
                end
            end
            if (in_took)
            begin
                predict_readback(in_item);
                items_sent++;
            end
            idle_cycles = (in_took || out_took) ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_mask_regs(1'b0, 1'b0);
        queue_directed();
        drain_phase();
        for (int p = 0; p < PHASES; p++)
        begin
            write_mask_regs(phase_check[p], phase_force[p]);
            queue_random_phase(PHASE_ITEMS);
            drain_phase();
        end
        $display("Run covered %0d items and %0d read results under all four mask settings,",
                 items_sent, results_seen);
        $display("with wrapped corners, full-size copies, odd rectangle ends and cut-off reads.");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[vram_rectangle_transfer_engine_core.f]
sv/vrte_pkg.sv
sv/vram_rectangle_transfer_engine_core.sv
sim/vram_rectangle_transfer_engine_core_tb.sv
